// ===== src/ehm_pkg.sv =====
`default_nettype none
package ehm_pkg;
    localparam int AXES_DEF = 4;

    localparam logic [1:0] OP_UPDATE    = 2'd0;
    localparam logic [1:0] OP_RESET_ONE = 2'd1;
    localparam logic [1:0] OP_RESET_ALL = 2'd2;

    localparam logic [2:0] REG_RECAL_VAR  = 3'd0;
    localparam logic [2:0] REG_DEGR_VAR   = 3'd1;
    localparam logic [2:0] REG_RECAL_DRF  = 3'd2;
    localparam logic [2:0] REG_DEGR_DRF   = 3'd3;
    localparam logic [2:0] REG_RECAL_QMIN = 3'd4;
    localparam logic [2:0] REG_NORM_QMIN  = 3'd5;
    localparam logic [2:0] REG_CRIT_QMIN  = 3'd6;

    localparam logic [1:0] HEALTH_OPTIMAL  = 2'd0;
    localparam logic [1:0] HEALTH_NORMAL   = 2'd1;
    localparam logic [1:0] HEALTH_DEGRADED = 2'd2;
    localparam logic [1:0] HEALTH_CRITICAL = 2'd3;

    localparam logic [21:0] HOUR_MS     = 22'd3600000;
    localparam logic [31:0] CRIT_FAULTS = 32'd10;
    localparam logic [31:0] MIN_SAMPLES = 32'd10;
endpackage
`default_nettype wire

// ===== src/encoder_health_monitor.sv =====
// An update runs S_UPD, then, when the hourly drift rate is recomputed, 2 multiply steps and
// a 70-step divide, then the 39-step quality divide (one bit per cycle in the shared divider),
// and its result is loaded in S_FIN once the output is free. Resets give no result.
// Throughput: input stall is high until the result is loaded, so a new update is taken only
// after the result of the last one is loaded; resets one per cycle.
// Reset (synchronous, active low) clears all axis state and loads default limits.
`default_nettype none
module encoder_health_monitor #(
    parameter int AXES = ehm_pkg::AXES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [1:0]  i_axis,
    input  wire logic signed [31:0] i_commanded_pos,
    input  wire logic signed [31:0] i_encoder_pos,
    input  wire logic        i_encoder_fault,
    input  wire logic [31:0] i_now_ms,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_axis_out,
    output logic signed [31:0] o_variance,
    output logic signed [31:0] o_peak_variance,
    output logic [31:0]      o_drift_rate,
    output logic [6:0]       o_quality,
    output logic [31:0]      o_fault_count,
    output logic             o_needs_recal,
    output logic [1:0]       o_health
);
    import ehm_pkg::*;

    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_MUL0 = 3'd2;
    localparam logic [2:0] S_MUL1 = 3'd3;
    localparam logic [2:0] S_DIVR = 3'd4;
    localparam logic [2:0] S_RATE = 3'd5;
    localparam logic [2:0] S_DIVQ = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]  r_state;
    logic [15:0] r_recal_var, r_degr_var, r_recal_drf, r_degr_drf;
    logic [6:0]  r_recal_qmin, r_norm_qmin, r_crit_qmin;

    logic signed [31:0] r_peak  [AXES];
    logic [47:0]        r_sum   [AXES];
    logic [31:0]        r_smp   [AXES];
    logic [31:0]        r_start [AXES];
    logic [31:0]        r_rate  [AXES];
    logic [31:0]        r_ftot  [AXES];
    logic [31:0]        r_rtot  [AXES];

    // latched request
    logic [AW-1:0]      r_idx;
    logic [1:0]         r_axis;
    logic signed [31:0] r_cmd, r_enc;
    logic               r_fault;
    logic [31:0]        r_now;

    // working values
    logic signed [31:0] r_var;
    logic [31:0]        r_vmag;
    logic [47:0]        r_dsum;
    logic [31:0]        r_el;
    logic [31:0]        r_reads, r_faults;
    logic [69:0]        r_prod;
    logic [6:0]         r_quality;

    // shared divider
    logic [71:0] r_dvd;
    logic [31:0] r_rem, r_dvs;
    logic [6:0]  r_cnt;
    logic [32:0] w_trial;
    logic        w_qbit;
    logic [71:0] n_dvd;
    logic [31:0] n_rem;

    assign w_trial = {r_rem, r_dvd[71]};
    assign w_qbit  = w_trial >= {1'b0, r_dvs};
    assign n_rem   = w_qbit ? 32'(w_trial - {1'b0, r_dvs}) : w_trial[31:0];
    assign n_dvd   = {r_dvd[70:0], w_qbit};

    // update datapath
    logic signed [32:0] w_diff;
    logic signed [31:0] w_var;
    logic [31:0]        w_vmag, w_pmag, w_ws, w_smp, w_el, w_faults, w_reads, w_fclamp;
    logic [48:0]        w_sum;
    logic [47:0]        w_sum_sat;
    logic               w_do_rate;

    assign w_diff = 33'(r_enc) - 33'(r_cmd);
    always_comb begin
        if (w_diff[32] != w_diff[31]) begin
            w_var = w_diff[32] ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
            w_var = w_diff[31:0];
        end
    end
    assign w_vmag    = w_var[31] ? 32'(-w_var) : w_var;
    assign w_pmag    = r_peak[r_idx][31] ? 32'(-r_peak[r_idx]) : r_peak[r_idx];
    assign w_ws      = (r_smp[r_idx] == 32'd0) ? r_now : r_start[r_idx];
    assign w_sum     = 49'(r_sum[r_idx]) + 49'(w_vmag);
    assign w_sum_sat = w_sum[48] ? {48{1'b1}} : w_sum[47:0];
    assign w_smp     = r_smp[r_idx] + 32'(r_smp[r_idx] != 32'hffffffff);
    assign w_el      = r_now - w_ws;
    assign w_do_rate = (w_smp > MIN_SAMPLES) && (w_el > 32'(HOUR_MS));
    assign w_faults  = r_ftot[r_idx] + 32'(r_fault && (r_ftot[r_idx] != 32'hffffffff));
    assign w_reads   = r_rtot[r_idx] + 32'(r_rtot[r_idx] != 32'hffffffff);
    assign w_fclamp  = (w_faults > w_reads) ? w_reads : w_faults;

    // drift sum times one hour, split in two 24-bit halves
    logic [23:0] w_mul_in;
    logic [45:0] w_mul;
    assign w_mul_in = (r_state == S_MUL0) ? r_dsum[23:0] : r_dsum[47:24];
    assign w_mul    = 46'(w_mul_in) * 46'(HOUR_MS);

    logic [38:0] w_qdvd;
    assign w_qdvd = 39'(r_reads - r_faults) * 39'd100;

    logic [31:0] w_rate_q;
    assign w_rate_q = (|n_dvd[69:32]) ? 32'hffffffff : n_dvd[31:0];

    logic w_accept, w_axis_ok;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_axis_ok  = 32'(i_axis) < 32'(AXES);

    logic w_out_free;
    assign w_out_free = !o_out_valid || !i_out_stall;

    function automatic logic [38:0] w_qdvd_upd(input logic [31:0] reads,
                                              input logic [31:0] faults);
        return 39'(reads - faults) * 39'd100;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            o_out_valid  <= 1'b0;
            r_recal_var  <= 16'd200;
            r_degr_var   <= 16'd500;
            r_recal_drf  <= 16'd100;
            r_degr_drf   <= 16'd200;
            r_recal_qmin <= 7'd90;
            r_norm_qmin  <= 7'd70;
            r_crit_qmin  <= 7'd50;
            for (int i = 0; i < AXES; i++) begin
                r_peak[i]  <= '0;
                r_sum[i]   <= '0;
                r_smp[i]   <= '0;
                r_start[i] <= '0;
                r_rate[i]  <= '0;
                r_ftot[i]  <= '0;
                r_rtot[i]  <= '0;
            end
        end else begin
            // a new result in S_FIN takes over the slot being freed
            if (o_out_valid && !i_out_stall && r_state != S_FIN) begin
                o_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RECAL_VAR:  r_recal_var  <= i_cfg_data;
                    REG_DEGR_VAR:   r_degr_var   <= i_cfg_data;
                    REG_RECAL_DRF:  r_recal_drf  <= i_cfg_data;
                    REG_DEGR_DRF:   r_degr_drf   <= i_cfg_data;
                    REG_RECAL_QMIN: r_recal_qmin <= i_cfg_data[6:0];
                    REG_NORM_QMIN:  r_norm_qmin  <= i_cfg_data[6:0];
                    REG_CRIT_QMIN:  r_crit_qmin  <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_idx   <= AW'(i_axis);
                        r_axis  <= i_axis;
                        r_cmd   <= i_commanded_pos;
                        r_enc   <= i_encoder_pos;
                        r_fault <= i_encoder_fault;
                        r_now   <= i_now_ms;
                        if (i_operation == OP_RESET_ALL) begin
                            for (int i = 0; i < AXES; i++) begin
                                r_peak[i] <= '0;
                                r_sum[i]  <= '0;
                                r_smp[i]  <= '0;
                                r_ftot[i] <= '0;
                                r_rtot[i] <= '0;
                            end
                        end else if (i_operation == OP_RESET_ONE && w_axis_ok) begin
                            r_sum[AW'(i_axis)]  <= '0;
                            r_smp[AW'(i_axis)]  <= '0;
                            r_ftot[AW'(i_axis)] <= '0;
                            r_rtot[AW'(i_axis)] <= '0;
                        end else if (i_operation == OP_UPDATE && w_axis_ok) begin
                            r_state <= S_UPD;
                        end
                    end
                end
                S_UPD: begin
                    r_var  <= w_var;
                    r_vmag <= w_vmag;
                    if (w_vmag > w_pmag) begin
                        r_peak[r_idx] <= w_var;
                    end
                    r_ftot[r_idx] <= w_faults;
                    r_rtot[r_idx] <= w_reads;
                    r_reads  <= w_reads;
                    r_faults <= w_fclamp;
                    r_dsum   <= w_sum_sat;
                    r_el     <= w_el;
                    if (w_do_rate) begin
                        r_sum[r_idx]   <= '0;
                        r_smp[r_idx]   <= '0;
                        r_start[r_idx] <= r_now;
                        r_state        <= S_MUL0;
                    end else begin
                        r_sum[r_idx]   <= w_sum_sat;
                        r_smp[r_idx]   <= w_smp;
                        r_start[r_idx] <= w_ws;
                        r_state        <= S_DIVQ;
                        r_dvd <= {w_qdvd_upd(w_reads, w_fclamp), 33'd0};
                        r_rem <= '0;
                        r_dvs <= w_reads;
                        r_cnt <= 7'd39;
                    end
                end
                S_MUL0: begin
                    r_prod  <= 70'(w_mul);
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_dvd   <= {r_prod + {w_mul, 24'd0}, 2'b00};
                    r_rem   <= '0;
                    r_dvs   <= r_el;
                    r_cnt   <= 7'd70;
                    r_state <= S_DIVR;
                end
                S_DIVR: begin
                    r_dvd <= n_dvd;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_rate[r_idx] <= w_rate_q;
                        r_state       <= S_RATE;
                    end
                end
                S_RATE: begin
                    r_dvd   <= {w_qdvd, 33'd0};
                    r_rem   <= '0;
                    r_dvs   <= r_reads;
                    r_cnt   <= 7'd39;
                    r_state <= S_DIVQ;
                end
                S_DIVQ: begin
                    r_dvd <= n_dvd;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_quality <= n_dvd[6:0];
                        r_state   <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        o_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result register, loaded as the request finishes
    logic w_recal;
    logic [1:0] w_health;
    logic [31:0] w_rate_cur;
    assign w_rate_cur = r_rate[r_idx];
    assign w_recal = (r_vmag > 32'(r_recal_var)) || (w_rate_cur > 32'(r_recal_drf)) ||
                     (r_quality < r_recal_qmin);
    always_comb begin
        if (r_quality < r_crit_qmin && r_ftot[r_idx] > CRIT_FAULTS) begin
            w_health = HEALTH_CRITICAL;
        end else if (r_vmag > 32'(r_degr_var) || w_rate_cur > 32'(r_degr_drf)) begin
            w_health = HEALTH_DEGRADED;
        end else if (r_quality < r_norm_qmin ||
                     (37'(r_faults) * 37'd20) > 37'(r_reads)) begin
            w_health = HEALTH_NORMAL;
        end else begin
            w_health = HEALTH_OPTIMAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && w_out_free) begin
            o_axis_out      <= r_axis;
            o_variance      <= r_var;
            o_peak_variance <= r_peak[r_idx];
            o_drift_rate    <= w_rate_cur;
            o_quality       <= r_quality;
            o_fault_count   <= r_ftot[r_idx];
            o_needs_recal   <= w_recal;
            o_health        <= w_health;
        end
    end

    a_upd_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_operation == OP_UPDATE && w_axis_ok) |=> (r_state == S_UPD))
        else $error("update request did not start the sequencer");
    a_quality_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_quality <= 7'd100))
        else $error("quality above 100");
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVR || r_state == S_DIVQ) |-> (r_cnt != 7'd0))
        else $error("divider step count ran out");
    a_critical: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_health == HEALTH_CRITICAL) |-> (o_fault_count > CRIT_FAULTS))
        else $error("critical health without enough faults");
endmodule
`default_nettype wire

// ===== dv/ehm_checker.sv =====
`timescale 1ns / 100ps
module ehm_checker #(
    parameter int AXES = ehm_pkg::AXES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [1:0]  i_axis,
    input  wire logic signed [31:0] i_commanded_pos,
    input  wire logic signed [31:0] i_encoder_pos,
    input  wire logic        i_encoder_fault,
    input  wire logic [31:0] i_now_ms,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [1:0]  i_axis_out,
    input  wire logic signed [31:0] i_variance,
    input  wire logic signed [31:0] i_peak_variance,
    input  wire logic [31:0] i_drift_rate,
    input  wire logic [6:0]  i_quality,
    input  wire logic [31:0] i_fault_count,
    input  wire logic        i_needs_recal,
    input  wire logic [1:0]  i_health,
    output int               o_errors,
    output int               o_pending
);
    import ehm_pkg::*;

    typedef struct packed {
        logic [1:0]         axis;
        logic signed [31:0] variance;
        logic signed [31:0] peak;
        logic [31:0]        drift_rate;
        logic [6:0]         quality;
        logic [31:0]        faults;
        logic               recal;
        logic [1:0]         health;
    } t_health_report;

    localparam logic [47:0] SUM_SAT = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] CNT_SAT = 32'hFFFF_FFFF;

    logic [15:0] lim_recal_var, lim_degr_var, lim_recal_drf, lim_degr_drf;
    logic [6:0]  qmin_recal, qmin_norm, qmin_crit;

    logic signed [31:0] peak_q[AXES];
    logic [47:0] sum_q[AXES];
    logic [31:0] samples_q[AXES];
    logic [31:0] win_start_q[AXES];
    logic [31:0] rate_q[AXES];
    logic [31:0] faults_q[AXES];
    logic [31:0] reads_q[AXES];

    t_health_report expected_reports[$];

    assign o_pending = expected_reports.size();

    function automatic logic [31:0] magnitude(logic signed [31:0] v);
        return v[31] ? 32'd0 - 32'(v) : 32'(v);
    endfunction

    function automatic void clear_counters(int a);
        faults_q[a] = '0;
        reads_q[a] = '0;
        sum_q[a] = '0;
        samples_q[a] = '0;
    endfunction

    function automatic void reset_model();
        lim_recal_var = 16'd200;
        lim_degr_var = 16'd500;
        lim_recal_drf = 16'd100;
        lim_degr_drf = 16'd200;
        qmin_recal = 7'd90;
        qmin_norm = 7'd70;
        qmin_crit = 7'd50;
        for (int a = 0; a < AXES; a++) begin
            clear_counters(a);
            peak_q[a] = '0;
            win_start_q[a] = '0;
            rate_q[a] = '0;
        end
        expected_reports.delete();
    endfunction

    function automatic void predict_health(logic [1:0] op, logic [1:0] ax,
                                           logic signed [31:0] cmd,
                                           logic signed [31:0] enc,
                                           logic flt, logic [31:0] now);
        longint d;
        logic signed [31:0] variance;
        logic [31:0] vmag, elapsed, reads, faults;
        logic [48:0] sum_next;
        logic [63:0] s, q, r, rate, quality;
        t_health_report rep;
        if (op == OP_RESET_ALL) begin
            for (int a = 0; a < AXES; a++) begin
                clear_counters(a);
                peak_q[a] = '0;
            end
            return;
        end
        if ((op != OP_UPDATE && op != OP_RESET_ONE) || ax >= AXES) return;
        if (op == OP_RESET_ONE) begin
            clear_counters(ax);
            return;
        end
        d = longint'(enc) - longint'(cmd);
        if (d > 64'sd2147483647) d = 64'sd2147483647;
        if (d < -64'sd2147483648) d = -64'sd2147483648;
        variance = d[31:0];
        vmag = magnitude(variance);
        if (vmag > magnitude(peak_q[ax])) peak_q[ax] = variance;

        if (samples_q[ax] == 0) win_start_q[ax] = now;
        sum_next = {1'b0, sum_q[ax]} + 49'(vmag);
        sum_q[ax] = sum_next[48] ? SUM_SAT : sum_next[47:0];
        if (samples_q[ax] != CNT_SAT) samples_q[ax]++;
        if (samples_q[ax] > MIN_SAMPLES) begin
            elapsed = now - win_start_q[ax];
            if (elapsed > 32'(HOUR_MS)) begin
                s = 64'(sum_q[ax]);
                q = s / elapsed;
                r = s % elapsed;
                rate = q * 64'(HOUR_MS) + (r * 64'(HOUR_MS)) / elapsed;
                rate_q[ax] = rate > 64'(CNT_SAT) ? CNT_SAT : rate[31:0];
                sum_q[ax] = '0;
                samples_q[ax] = '0;
                win_start_q[ax] = now;
            end
        end

        if (flt && faults_q[ax] != CNT_SAT) faults_q[ax]++;
        if (reads_q[ax] != CNT_SAT) reads_q[ax]++;
        reads = reads_q[ax];
        faults = faults_q[ax] > reads ? reads : faults_q[ax];
        quality = (64'(reads - faults) * 100) / reads;

        rep.axis = ax;
        rep.variance = variance;
        rep.peak = peak_q[ax];
        rep.drift_rate = rate_q[ax];
        rep.quality = quality[6:0];
        rep.faults = faults_q[ax];
        rep.recal = vmag > lim_recal_var || rate_q[ax] > lim_recal_drf ||
                    quality < qmin_recal;
        if (quality < qmin_crit && faults_q[ax] > CRIT_FAULTS)
            rep.health = HEALTH_CRITICAL;
        else if (vmag > lim_degr_var || rate_q[ax] > lim_degr_drf)
            rep.health = HEALTH_DEGRADED;
        else if (quality < qmin_norm || 64'(faults) * 20 > 64'(reads))
            rep.health = HEALTH_NORMAL;
        else
            rep.health = HEALTH_OPTIMAL;
        expected_reports.push_back(rep);
    endfunction

    function automatic void check_report();
        t_health_report exp_rep, got;
        got = '{i_axis_out, i_variance, i_peak_variance, i_drift_rate, i_quality,
                i_fault_count, i_needs_recal, i_health};
        if (expected_reports.size() == 0) begin
            o_errors++;
            if (o_errors <= 10) $display("unexpected result for axis %0d", i_axis_out);
            return;
        end
        exp_rep = expected_reports.pop_front();
        if (got !== exp_rep) begin
            o_errors++;
            if (o_errors <= 10)
                $display({"mismatch axis exp %0d got %0d | var %0d/%0d | peak %0d/%0d |",
                          " rate %0d/%0d | q %0d/%0d | faults %0d/%0d | recal %0b/%0b |",
                          " health %0d/%0d"},
                         exp_rep.axis, got.axis, exp_rep.variance, got.variance,
                         exp_rep.peak, got.peak, exp_rep.drift_rate, got.drift_rate,
                         exp_rep.quality, got.quality, exp_rep.faults, got.faults,
                         exp_rep.recal, got.recal, exp_rep.health, got.health);
        end
    endfunction

    initial begin
        o_errors = 0;
        reset_model();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_out_valid && !i_out_stall) check_report();
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RECAL_VAR:  lim_recal_var = i_cfg_data;
                    REG_DEGR_VAR:   lim_degr_var = i_cfg_data;
                    REG_RECAL_DRF:  lim_recal_drf = i_cfg_data;
                    REG_DEGR_DRF:   lim_degr_drf = i_cfg_data;
                    REG_RECAL_QMIN: qmin_recal = i_cfg_data[6:0];
                    REG_NORM_QMIN:  qmin_norm = i_cfg_data[6:0];
                    REG_CRIT_QMIN:  qmin_crit = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                predict_health(i_operation, i_axis, i_commanded_pos, i_encoder_pos,
                               i_encoder_fault, i_now_ms);
        end
    end
endmodule

// ===== dv/tb_encoder_health_monitor.sv =====
`timescale 1ns / 100ps
module tb_encoder_health_monitor;
    import ehm_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 200;
    localparam int PHASES = 5;
    localparam int ITEMS_PER_PHASE = 210;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_operation = OP_UPDATE;
    logic [1:0]  i_axis = '0;
    logic signed [31:0] i_commanded_pos = '0;
    logic signed [31:0] i_encoder_pos = '0;
    logic        i_encoder_fault = 1'b0;
    logic [31:0] i_now_ms = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_axis_out;
    logic signed [31:0] o_variance, o_peak_variance;
    logic [31:0] o_drift_rate, o_fault_count;
    logic [6:0]  o_quality;
    logic        o_needs_recal;
    logic [1:0]  o_health;

    int errors, pending;
    int idle_cycles = 0;
    int burst_left = 0;
    int fault_pct = 10;
    int stall_mode = 0, stall_left = 0;
    logic [31:0] clock_ms = '0;

    always #5 i_clk = ~i_clk;

    encoder_health_monitor u_dut (.*);

    ehm_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_operation, .i_axis,
        .i_commanded_pos, .i_encoder_pos, .i_encoder_fault, .i_now_ms,
        .i_out_valid(o_out_valid), .i_out_stall, .i_axis_out(o_axis_out),
        .i_variance(o_variance), .i_peak_variance(o_peak_variance),
        .i_drift_rate(o_drift_rate), .i_quality(o_quality),
        .i_fault_count(o_fault_count), .i_needs_recal(o_needs_recal),
        .i_health(o_health), .o_errors(errors), .o_pending(pending)
    );

    // receiver back-pressure in four randomly chosen modes
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= $urandom_range(0, 1);
            2: i_out_stall <= ($urandom_range(0, 7) != 0);
            default: i_out_stall <= stall_left[3];
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send(logic [1:0] op, logic [1:0] ax, logic signed [31:0] cmd,
                        logic signed [31:0] enc, logic flt, logic [31:0] now);
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_axis <= ax;
        i_commanded_pos <= cmd;
        i_encoder_pos <= enc;
        i_encoder_fault <= flt;
        i_now_ms <= now;
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_limits(logic [15:0] lims[7]);
        for (int i = 0; i < 7; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= 3'(i);
            i_cfg_data <= lims[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_request();
        int r, mode;
        logic signed [31:0] cmd, enc;
        logic [1:0] op;
        r = $urandom_range(0, 99);
        op = r < 88 ? OP_UPDATE : r < 93 ? OP_RESET_ONE : r < 95 ? OP_RESET_ALL : OP_UNUSED;
        mode = $urandom_range(0, 19);
        cmd = $urandom;
        if (mode < 14) begin
            enc = cmd + $signed($urandom_range(0, 2000)) - 1000;
        end else if (mode < 17) begin
            enc = $urandom;
        end else begin
            cmd = $signed($urandom_range(0, 200)) - 100;
            enc = cmd + $signed($urandom_range(0, 100)) - 50;
        end
        if ($urandom_range(0, 49) == 0)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, 400000);
        send(op, 2'($urandom_range(0, 3)), cmd, enc,
             $urandom_range(0, 99) < fault_pct, clock_ms);
    endtask

    initial begin
        logic [15:0] lims[7];
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: saturation both ways, peak tie, time extremes, all ops
        send(OP_UPDATE, 2'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 32'd0);
        send(OP_UPDATE, 2'd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 32'hFFFF_FFFF);
        send(OP_UPDATE, 2'd2, 32'sd0, 32'sd300, 1'b0, 32'd10);
        send(OP_UPDATE, 2'd2, 32'sd300, 32'sd0, 1'b0, 32'd20);
        send(OP_UPDATE, 2'd3, -32'sd5, -32'sd5, 1'b1, 32'd30);
        send(OP_UNUSED, 2'd0, 32'sd1, 32'sd999, 1'b1, 32'd40);
        send(OP_RESET_ONE, 2'd2, 32'sd0, 32'sd0, 1'b0, 32'd50);
        send(OP_UPDATE, 2'd2, 32'sd0, 32'sd100, 1'b0, 32'd60);
        // many faults on one axis, with a drift window spanning over an hour
        for (int i = 0; i < 12; i++)
            send(OP_UPDATE, 2'd3, 32'sd0, 32'sd150, 1'b1, 32'hFFF0_0000 + i * 400000);
        send(OP_RESET_ALL, 2'd1, 32'sd0, 32'sd0, 1'b0, 32'd0);
        send(OP_UPDATE, 2'd0, 32'sd7, 32'sd3, 1'b0, 32'd70);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: lims = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
                1: lims = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd100, 16'd100, 16'd100};
                default: lims = '{16'($urandom_range(0, 1000)), 16'($urandom_range(0, 2000)),
                                  16'($urandom_range(0, 500)), 16'($urandom_range(0, 1000)),
                                  16'($urandom_range(0, 100)), 16'($urandom_range(0, 100)),
                                  16'($urandom_range(0, 100))};
            endcase
            program_limits(lims);
            fault_pct = $urandom_range(0, 60);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                random_request();
                if (n == ITEMS_PER_PHASE / 2) drain();
            end
            drain();
        end

        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
